/* rtl/core/bos_pkg.sv */
// Package for the odometer and speed filter: types, codes and constants.
package bos_pkg;

  localparam int HistSlots = 10;
  localparam int WindowTicks = 100;
  localparam int SlotW = 4;
  localparam int NumCfg = 8;

  localparam logic [1:0] OpPulse = 2'd0;
  localparam logic [1:0] OpEval = 2'd1;
  localparam logic [1:0] OpPreset = 2'd2;

  localparam logic [2:0] CfgDist = 3'd0;
  localparam logic [2:0] CfgDebounce = 3'd1;
  localparam logic [2:0] CfgMaxPulses = 3'd2;
  localparam logic [2:0] CfgFloor = 3'd3;
  localparam logic [2:0] CfgWalk = 3'd4;
  localparam logic [2:0] CfgSavePeriod = 3'd5;
  localparam logic [2:0] CfgSlowEn = 3'd6;
  localparam logic [2:0] CfgPatience = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] now_tick;
    logic [31:0] mileage_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [31:0] valid_distance;
    logic        save_request;
    logic [31:0] save_value;
  } out_item_t;

  // divider handshake between sequencer and shared divide unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* rtl/core/bos_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module bos_div import bos_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [40:0] dividend_i,
  input  logic [15:0] divisor_i,
  output div_ctl_t    ctl_o,
  output logic [40:0] quot_o
);
  logic [40:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic [17:0] shifted;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, quot_q[40]};
    trial = 17'(shifted - {2'b0, dvs_q});
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd41;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {2'b0, dvs_q}) begin
        rem_d = trial;
        quot_d = {quot_q[39:0], 1'b1};
      end else begin
        rem_d = shifted[16:0];
        quot_d = {quot_q[39:0], 1'b0};
      end
      cnt_d = 6'(cnt_q - 6'd1);
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quot_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("divider done without busy");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !start_i |=> !busy_q) else $error("divider started spontaneously");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("divider busy with zero count");
endmodule

/* rtl/core/bike_odometer_speed_filter.sv */
// Top level: wheel-pulse odometer with windowed speed, moving average and save logic.
// Pulse, preset and unknown transactions load the result register at the accepting edge, so
// the result is valid from the next cycle. An evaluate that does not close the window passes
// through the finish state, which loads the result register. An evaluate that closes the
// window runs the 41-bit delta*360/elapsed division in the shared divider, updates the
// history in the history state, has the same divider compute the 20-bit history average,
// and loads the result in the finish state. No new item is taken until the result register
// is free and the sequencer is back in idle.
module bike_odometer_speed_filter import bos_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv1 = 3'd1;
  localparam logic [2:0] StHist = 3'd2;
  localparam logic [2:0] StDiv2 = 3'd3;
  localparam logic [2:0] StFin = 3'd4;

  logic [15:0] dpp_q, deb_q, maxp_q, floor_q, walk_q, per_q, pat_q;
  logic        slow_en_q;

  logic [2:0]  st_q, st_d;
  logic [31:0] raw_q, ride_q, prior_q, wsd_q;
  logic [15:0] savec_q, slowc_q, filt_q, lpt_q, wst_q, wpc_q;
  logic [15:0] hist_q [HistSlots];
  logic [19:0] hsum_q;
  logic [SlotW-1:0] hslot_q, hfill_q;
  logic [15:0] now_q, spd_q;
  logic        res_v_q;
  out_item_t   res_q;

  logic        div_start;
  logic [40:0] div_dvd, div_quot;
  logic [15:0] div_dvs;
  div_ctl_t    div_ctl;

  bos_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .ctl_o(div_ctl), .quot_o(div_quot)
  );

  logic        acc;
  logic [15:0] elapsed_in, gap;
  logic [31:0] delta;
  logic [40:0] prod;
  logic [15:0] filt_fin;
  logic        riding;
  logic [15:0] savec_inc;
  logic [SlotW-1:0] slot_nx;
  logic [15:0] spd_sat;
  logic [19:0] hsum_nx;
  logic [SlotW-1:0] hfill_nx;

  assign in_ready_o = (st_q == StIdle) && !res_v_q;
  assign acc = in_valid_i && in_ready_o;
  assign elapsed_in = 16'(in_data_i.now_tick - wst_q);
  assign gap = 16'(in_data_i.now_tick - lpt_q);
  assign delta = (raw_q >= wsd_q) ? 32'(raw_q - wsd_q) : 32'd0;
  assign prod = {delta, 9'd0} - {2'd0, delta, 7'd0} - {3'd0, delta, 6'd0}
              + {4'd0, delta, 5'd0} + {6'd0, delta, 3'd0};
  assign spd_sat = (div_quot > 41'hFFFF) ? 16'hFFFF : div_quot[15:0];
  assign slot_nx = (hslot_q == SlotW'(HistSlots - 1)) ? '0 : SlotW'(hslot_q + 1'b1);
  // history after this window's speed goes in; the average divides these
  assign hsum_nx = 20'(hsum_q - {4'd0, hist_q[hslot_q]} + {4'd0, spd_q});
  assign hfill_nx = (hfill_q < SlotW'(HistSlots)) ? SlotW'(hfill_q + 1'b1) : hfill_q;

  always_comb begin
    div_start = 1'b0;
    div_dvd = prod;
    div_dvs = elapsed_in;
    if (acc && in_data_i.operation == OpEval && elapsed_in >= 16'(WindowTicks)
        && elapsed_in != 16'd0) begin
      div_start = 1'b1;
    end else if (st_q == StHist) begin
      div_start = 1'b1;
      div_dvd = {21'd0, hsum_nx};
      div_dvs = {12'd0, hfill_nx};
    end
  end

  always_comb begin
    filt_fin = (filt_q < floor_q) ? 16'd0 : filt_q;
    riding = filt_fin >= walk_q;
    savec_inc = 16'(savec_q + 16'd1);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc) st_d = div_start ? StDiv1 :
                              (in_data_i.operation == OpEval) ? StFin : StIdle;
      StDiv1: if (div_ctl.done) st_d = StHist;
      StHist: st_d = StDiv2;
      StDiv2: if (div_ctl.done) st_d = StFin;
      StFin:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpp_q <= 16'd210; deb_q <= 16'd5; maxp_q <= 16'd20; floor_q <= 16'd100;
      walk_q <= 16'd600; per_q <= 16'd100; slow_en_q <= 1'b0; pat_q <= 16'd1000;
      st_q <= StIdle; res_v_q <= 1'b0;
      raw_q <= '0; ride_q <= '0; prior_q <= '0; wsd_q <= '0;
      savec_q <= '0; slowc_q <= '0; filt_q <= '0; lpt_q <= '0; wst_q <= '0; wpc_q <= '0;
      hsum_q <= '0; hslot_q <= '0; hfill_q <= '0;
      for (int i = 0; i < HistSlots; i++) hist_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDist:       dpp_q <= cfg_data_i;
          CfgDebounce:   deb_q <= cfg_data_i;
          CfgMaxPulses:  maxp_q <= cfg_data_i;
          CfgFloor:      floor_q <= cfg_data_i;
          CfgWalk:       walk_q <= cfg_data_i;
          CfgSavePeriod: per_q <= cfg_data_i;
          CfgSlowEn:     slow_en_q <= cfg_data_i[0];
          CfgPatience:   pat_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_v_q && out_ready_i) res_v_q <= 1'b0;

      if (acc) begin
        now_q <= in_data_i.now_tick;
        unique case (in_data_i.operation)
          OpPulse: begin
            if (gap >= deb_q) begin
              lpt_q <= in_data_i.now_tick;
              if (raw_q < 32'(32'hFFFF_FFFF - {16'd0, dpp_q}))
                raw_q <= 32'(raw_q + {16'd0, dpp_q});
              if (wpc_q != 16'hFFFF) wpc_q <= 16'(wpc_q + 16'd1);
            end
            res_v_q <= 1'b1;
            res_q <= '{speed: filt_q, valid_distance: ride_q, save_request: 1'b0,
                       save_value: 32'd0};
          end
          OpPreset: begin
            raw_q <= in_data_i.mileage_value; ride_q <= in_data_i.mileage_value;
            prior_q <= in_data_i.mileage_value; wsd_q <= in_data_i.mileage_value;
            savec_q <= '0; slowc_q <= '0; wst_q <= '0; wpc_q <= '0;
            for (int i = 0; i < HistSlots; i++) hist_q[i] <= '0;
            hsum_q <= '0; hslot_q <= '0; hfill_q <= '0; filt_q <= '0;
            res_v_q <= 1'b1;
            res_q <= '{speed: 16'd0, valid_distance: in_data_i.mileage_value,
                       save_request: 1'b1, save_value: in_data_i.mileage_value};
          end
          OpEval: ;
          default: begin
            res_v_q <= 1'b1;
            res_q <= '{speed: filt_q, valid_distance: ride_q, save_request: 1'b0,
                       save_value: 32'd0};
          end
        endcase
      end

      if (st_q == StDiv1 && div_ctl.done) begin
        spd_q <= (wpc_q > maxp_q) ? 16'd0 : spd_sat;
        wsd_q <= raw_q;
        wst_q <= now_q;
        wpc_q <= '0;
      end
      if (st_q == StHist) begin
        hsum_q <= hsum_nx;
        hist_q[hslot_q] <= spd_q;
        hslot_q <= slot_nx;
        hfill_q <= hfill_nx;
      end
      if (st_q == StDiv2 && div_ctl.done) filt_q <= div_quot[15:0];

      if (st_q == StFin) begin
        filt_q <= filt_fin;
        if (riding) ride_q <= 32'(ride_q + raw_q - prior_q);
        prior_q <= raw_q;
        res_v_q <= 1'b1;
        res_q.speed <= filt_fin;
        res_q.valid_distance <= riding ? 32'(ride_q + raw_q - prior_q) : ride_q;
        res_q.save_request <= 1'b0;
        res_q.save_value <= 32'd0;
        savec_q <= savec_inc;
        if (riding) slowc_q <= '0;
        else if (slowc_q != 16'hFFFF) slowc_q <= 16'(slowc_q + 16'd1);
        if (savec_inc >= per_q) begin
          savec_q <= '0;
          if (filt_fin > 16'd50 || (slow_en_q &&
              (riding ? 16'd0 : (slowc_q != 16'hFFFF ? 16'(slowc_q + 16'd1) : slowc_q))
              >= pat_q)) begin
            res_q.save_request <= 1'b1;
            res_q.save_value <= riding ? 32'(ride_q + raw_q - prior_q) : ride_q;
            slowc_q <= '0;
          end
        end
      end
    end
  end

  assign out_valid_o = res_v_q;
  assign out_data_o = res_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hfill_q <= SlotW'(HistSlots) && hslot_q < SlotW'(HistSlots))
    else $error("history index out of range");
  a_hist_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StHist |=> hfill_q != '0) else $error("history empty at average");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !in_ready_o) else $error("ready while sequencer busy");
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StFin |=> res_v_q) else $error("evaluate finished without result");
endmodule
